@@ sv/bmd_pkg.sv @@
// bmd_pkg: shared types and constants for the bgp message deframer
// no dependencies; imported by every module of the block
package bmd_pkg;

  // marker run length and minimum message length
  localparam int unsigned MARKER_BYTES = 16;
  localparam int unsigned RUN_W        = $clog2(MARKER_BYTES + 1);
  localparam logic [15:0] MIN_LEN      = 16'd19;
  localparam logic [7:0]  MARKER_BYTE  = 8'hff;

  // result status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_SHORT_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_capture;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [15:0] msg_length;
    logic        skipped_garbage;
    logic [1:0]  status;
  } out_word_t;

endpackage

@@ sv/bmd_if.sv @@
// bmd_if: valid/ready channel interfaces for byte input and message results
// no dependencies; field widths match the word types in bmd_pkg
interface bmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_capture;

  modport source (output valid, output data_byte, output end_of_capture, input ready);
  modport sink   (input valid, input data_byte, input end_of_capture, output ready);
endinterface

interface bmd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [15:0] msg_length;
  logic        skipped_garbage;
  logic [1:0]  status;

  modport source (output valid, output msg_type, output msg_length,
                  output skipped_garbage, output status, input ready);
  modport sink   (input valid, input msg_type, input msg_length,
                  input skipped_garbage, input status, output ready);
endinterface

@@ sv/bmd_core.sv @@
// bmd_core: framing state and per-byte next-state / result logic
// depends on bmd_pkg
module bmd_core
  import bmd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [RUN_W-1:0] marker_run;
    logic [1:0]       header_index;
    logic [15:0]      length_reg;
    logic [7:0]       type_reg;
    logic [15:0]      body_remaining;
    logic             garbage_seen;
  } fr_state_t;

  localparam fr_state_t IdleState = '{phase: PH_HUNT, default: '0};

  fr_state_t st_q, st_d;
  logic      emit;
  out_word_t res;

  always_comb begin
    st_d = st_q;
    emit = 1'b0;
    res  = '0;
    unique case (st_q.phase)
      PH_HEAD: begin
        unique case (st_q.header_index)
          2'd0: begin
            st_d.length_reg   = {word_i.data_byte, 8'h00};
            st_d.header_index = 2'd1;
          end
          2'd1: begin
            st_d.length_reg   = {st_q.length_reg[15:8], word_i.data_byte};
            st_d.header_index = 2'd2;
          end
          default: begin
            st_d.type_reg       = word_i.data_byte;
            res.msg_type        = word_i.data_byte;
            res.msg_length      = st_q.length_reg;
            res.skipped_garbage = st_q.garbage_seen;
            if (st_q.length_reg < MIN_LEN) begin
              emit       = 1'b1;
              res.status = ST_SHORT_LEN;
              st_d       = IdleState;
            end else if (st_q.length_reg == MIN_LEN) begin
              emit       = 1'b1;
              res.status = ST_COMPLETE;
              st_d       = IdleState;
            end else begin
              st_d.body_remaining = st_q.length_reg - MIN_LEN;
              st_d.phase          = PH_BODY;
            end
          end
        endcase
      end
      PH_BODY: begin
        st_d.body_remaining = st_q.body_remaining - 16'd1;
        if (st_q.body_remaining == 16'd1) begin
          emit                = 1'b1;
          res.msg_type        = st_q.type_reg;
          res.msg_length      = st_q.length_reg;
          res.skipped_garbage = st_q.garbage_seen;
          res.status          = ST_COMPLETE;
          st_d                = IdleState;
        end
      end
      default: begin
        // hunting; an unused phase code behaves the same
        st_d.phase = PH_HUNT;
        if (word_i.data_byte == MARKER_BYTE) begin
          if (st_q.marker_run == RUN_W'(MARKER_BYTES - 1)) begin
            st_d.phase        = PH_HEAD;
            st_d.header_index = 2'd0;
            st_d.length_reg   = '0;
            st_d.type_reg     = '0;
            st_d.marker_run   = '0;
          end else begin
            st_d.marker_run = st_q.marker_run + RUN_W'(1);
          end
        end else begin
          st_d.marker_run   = '0;
          st_d.garbage_seen = 1'b1;
        end
      end
    endcase

    if (word_i.end_of_capture) begin
      // capture ended inside a header or body: report it truncated
      if (!emit && (st_d.phase == PH_HEAD || st_d.phase == PH_BODY)) begin
        emit                = 1'b1;
        res.msg_type        = (st_d.phase == PH_BODY) ? st_d.type_reg : 8'h00;
        res.msg_length      = (st_d.phase == PH_BODY || st_d.header_index == 2'd2)
                              ? st_d.length_reg : 16'h0000;
        res.skipped_garbage = st_d.garbage_seen;
        res.status          = ST_TRUNCATED;
      end
      st_d = IdleState;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= IdleState;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign res_valid_o = step_i & emit;
  assign res_o       = res;

endmodule

@@ sv/bmd_out_buf.sv @@
// bmd_out_buf: two-entry result queue that decouples the framer from the sink
// depends on bmd_pkg
module bmd_out_buf
  import bmd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t push_word_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output out_word_t word_o
);

  out_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = pop_i & (cnt_q != 2'd0);
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/bgp_message_deframer.sv @@
// bgp_message_deframer: top level, input byte register, framer core, result queue
// depends on bmd_pkg, bmd_if, bmd_core, bmd_out_buf
// a byte accepted into the input register has its result (if any) pushed into the result queue when it is processed
// throughput: one byte per cycle while the result queue is not full
// results queue in a two-entry buffer; input stalls only when it is full and a byte is staged
// reset: asynchronous active-low, returns the framer to marker hunting and empties the queue
module bgp_message_deframer
  import bmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  bmd_in_if.sink    in_i,
  bmd_out_if.source out_o
);

  // input register stage
  logic      stg_v_q;
  in_word_t  stg_q;
  logic      advance;
  logic      buf_full;

  // framer result toward the queue
  logic      res_valid;
  out_word_t res;
  out_word_t out_word;

  // the staged byte is processed once there is room for a possible result
  assign advance    = stg_v_q & ~buf_full;
  assign in_i.ready = ~stg_v_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_v_q <= in_i.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stg_q <= '{data_byte: in_i.data_byte, end_of_capture: in_i.end_of_capture};
    end
  end

  // marker hunt, header capture and body count
  bmd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .word_i      (stg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue, parts the framer from a stalled sink
  bmd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res),
    .full_o      (buf_full),
    .valid_o     (out_o.valid),
    .pop_i       (out_o.ready),
    .word_o      (out_word)
  );

  assign out_o.msg_type        = out_word.msg_type;
  assign out_o.msg_length      = out_word.msg_length;
  assign out_o.skipped_garbage = out_word.skipped_garbage;
  assign out_o.status          = out_word.status;

endmodule
